// ----- src/bcl_pkg.sv -----
// Shared types, constants and helper functions for the blink code LED identifier.
// Has no dependencies. The RTL modules in src import it, all but bcl_checker.
`default_nettype none

package bcl_pkg;

  // Field widths that are fixed by the stream format.
  localparam int unsigned PAT_W   = 10;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned DIST_W  = 4;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned AREA_W  = 16;
  localparam int unsigned AGE_W   = 8;
  localparam int unsigned EIDX_W  = 4;
  localparam int unsigned LEDS_W  = 5;
  localparam int unsigned SCALE_W = AREA_W + 4;

  // Brightness hysteresis ratio of eleven to ten.
  localparam logic [3:0] RATIO_LO = 4'd10;
  localparam logic [3:0] RATIO_HI = 4'd11;

  // Configuration register indices.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_SOURCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AGE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MAX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MAX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEDS_IN_USE   = 3'd5;

  // Request kinds carried in tuser.
  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_TABLE = 1'b1;

  // Symbol source selection.
  localparam logic SRC_BRIGHTNESS = 1'b0;

  // One entry of the slot state memory.
  typedef struct packed {
    logic            id_valid;
    logic [ID_W-1:0] id;
    logic [PAT_W-1:0] pattern;
  } slot_entry_t;

  // Hamming distance between two patterns.
  function automatic logic [DIST_W-1:0] bit_dist(input logic [PAT_W-1:0] a,
                                                 input logic [PAT_W-1:0] b);
    logic [PAT_W-1:0]  x;
    logic [DIST_W-1:0] n;
    x = a ^ b;
    n = '0;
    for (int unsigned i = 0; i < PAT_W; i++) begin
      n = n + DIST_W'(x[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- src/bcl_slot_mem.sv -----
// Slot state memory: one read port with registered data, one write port.
// Sweeps every entry to zero after reset. Depends on bcl_pkg.
`default_nettype none

module bcl_slot_mem
  import bcl_pkg::*;
#(
  parameter int unsigned MAX_BLOBS = 64,
  parameter int unsigned SLOT_AW   = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               rd_en_i,
  input  wire logic [SLOT_AW-1:0] rd_addr_i,
  output      slot_entry_t        rd_data_o,
  input  wire logic               wr_en_i,
  input  wire logic [SLOT_AW-1:0] wr_addr_i,
  input  wire slot_entry_t        wr_data_i,
  output      logic               clr_busy_o
);

  slot_entry_t        mem [MAX_BLOBS];
  slot_entry_t        rd_data_q;
  logic [SLOT_AW-1:0] clr_addr_q, clr_addr_d;
  logic               clr_busy_q, clr_busy_d;
  logic               we;
  logic [SLOT_AW-1:0] waddr;
  slot_entry_t        wdata;

  // Clearing pass: one entry per cycle from address zero upwards.
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + SLOT_AW'(1);
      if (clr_addr_q == SLOT_AW'(MAX_BLOBS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // The sweep owns the write port until it finishes.
  assign we    = clr_busy_q || wr_en_i;
  assign waddr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_busy_q ? slot_entry_t'('0) : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule

`default_nettype wire

// ----- src/bcl_match.sv -----
// LED pattern table and its parallel search for a close enough entry.
// Returns the first entry within the match distance. Depends on bcl_pkg.
`default_nettype none

module bcl_match
  import bcl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [EIDX_W-1:0] wr_index_i,
  input  wire logic [PAT_W-1:0]  wr_pattern_i,
  input  wire logic [ID_W-1:0]   wr_id_i,
  input  wire logic [PAT_W-1:0]  key_i,
  input  wire logic [LEDS_W-1:0] leds_in_use_i,
  input  wire logic [DIST_W-1:0] max_dist_i,
  output      logic              hit_o,
  output      logic [ID_W-1:0]   hit_id_o
);

  localparam int unsigned TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IDX_EW = TBL_AW + EIDX_W;
  localparam int unsigned CNT_W  = 9;

  logic [PAT_W-1:0]  tbl_pat_q [TABLE_DEPTH];
  logic [ID_W-1:0]   tbl_id_q  [TABLE_DEPTH];
  logic [IDX_EW-1:0] idx_ext;
  logic              idx_ok;

  // Writes beyond the table are dropped.
  assign idx_ext = {{TBL_AW{1'b0}}, wr_index_i};
  assign idx_ok  = idx_ext < IDX_EW'(TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (wr_en_i && idx_ok) begin
      tbl_pat_q[idx_ext[TBL_AW-1:0]] <= wr_pattern_i;
      tbl_id_q[idx_ext[TBL_AW-1:0]]  <= wr_id_i;
    end
  end

  // Compare all entries at once; scanning downwards leaves the lowest hit.
  always_comb begin
    hit_o    = 1'b0;
    hit_id_o = '0;
    for (int j = TABLE_DEPTH - 1; j >= 0; j--) begin
      if ((CNT_W'(j) < {{(CNT_W - LEDS_W){1'b0}}, leds_in_use_i}) &&
          (bit_dist(key_i, tbl_pat_q[j]) <= max_dist_i)) begin
        hit_o    = 1'b1;
        hit_id_o = tbl_id_q[j];
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/blink_code_led_identifier.sv -----
// Top level of the blink code LED identifier: stream ports, configuration
// registers and the slot update sequencer. Depends on bcl_pkg, bcl_slot_mem
// and bcl_match.
//
// Usage: each request on the slave stream is either a frame observation of
// one blob slot (tuser low) or a write of one LED pattern table entry (tuser
// high). Every request gives exactly one result on the master stream: the
// slot's new blink pattern, the ready and sync flags and the bound LED id, or
// all zero for table writes, cleared slots and slots beyond the memory.
// Configuration writes take effect at the clock edge that sees cfg_we_i high.
// An accepted request reads its slot entry from the memory; the update, table
// search and write-back follow in ST_CALC, and no new request is taken until
// the block is back in ST_IDLE. After reset the slot memory is swept to zero,
// and s_axis_tready stays low until the sweep is done. When the receiver
// stalls, the result waits in the output register and the block holds its
// update until that register is free; a new request may be accepted while a
// finished result waits.
`default_nettype none

module blink_code_led_identifier
  import bcl_pkg::*;
#(
  parameter int unsigned MAX_BLOBS   = 64,
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Slave stream.
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // tdata: slot, area, prev_area, age, colour, entry_index, entry_pattern,
  // entry_led_id, zero padding
  input  wire logic [71:0]          s_axis_tdata,
  // tuser: action
  input  wire logic                 s_axis_tuser,
  // Master stream.
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tdata: pattern, ready_res, sync_found, led_known, led_id, zero padding
  output      logic [23:0]          m_axis_tdata,
  // Configuration write port.
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [PAT_W-1:0]     cfg_wdata_i
);

  localparam int unsigned SLOT_AW = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
  localparam int unsigned SLOT_EW = SLOT_AW + SLOT_W;

  typedef enum logic {ST_IDLE, ST_CALC} state_e;

  // Unpacked request fields.
  logic [SLOT_W-1:0] in_slot;
  logic [AREA_W-1:0] in_area, in_prev_area;
  logic [AGE_W-1:0]  in_age;
  logic [1:0]        in_colour;
  logic [EIDX_W-1:0] in_eidx;
  logic [PAT_W-1:0]  in_epat;
  logic [ID_W-1:0]   in_eid;

  assign in_slot      = s_axis_tdata[5:0];
  assign in_area      = s_axis_tdata[21:6];
  assign in_prev_area = s_axis_tdata[37:22];
  assign in_age       = s_axis_tdata[45:38];
  assign in_colour    = s_axis_tdata[47:46];
  assign in_eidx      = s_axis_tdata[51:48];
  assign in_epat      = s_axis_tdata[61:52];
  assign in_eid       = s_axis_tdata[69:62];

  // Configuration registers.
  logic              src_q;
  logic [AGE_W-1:0]  min_age_q;
  logic [PAT_W-1:0]  sync_word_q;
  logic [DIST_W-1:0] sync_max_q;
  logic [DIST_W-1:0] match_max_q;
  logic [LEDS_W-1:0] leds_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q       <= SRC_BRIGHTNESS;
      min_age_q   <= AGE_W'(9);
      sync_word_q <= PAT_W'(10'h3FF);
      sync_max_q  <= DIST_W'(1);
      match_max_q <= '0;
      leds_q      <= LEDS_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYMBOL_SOURCE: src_q       <= cfg_wdata_i[0];
        CFG_MIN_AGE:       min_age_q   <= cfg_wdata_i[AGE_W-1:0];
        CFG_SYNC_WORD:     sync_word_q <= cfg_wdata_i;
        CFG_SYNC_MAX:      sync_max_q  <= cfg_wdata_i[DIST_W-1:0];
        CFG_MATCH_MAX:     match_max_q <= cfg_wdata_i[DIST_W-1:0];
        CFG_LEDS_IN_USE:   leds_q      <= cfg_wdata_i[LEDS_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and output registers.
  state_e             state_q, state_d;
  logic               m_valid_q, m_valid_d;
  logic [23:0]        m_data_q, m_data_d;
  // Request payload held for the update cycle.
  logic               act_q;
  logic               in_range_q;
  logic [SLOT_AW-1:0] slot_q;
  logic [AREA_W-1:0]  area_q, prev_area_q;
  logic [AGE_W-1:0]   age_q;
  logic [1:0]         colour_q;

  logic               accept;
  logic               clr_busy;
  logic [SLOT_EW-1:0] slot_ext;
  logic               slot_ok;
  logic               out_free;
  logic               finish;
  slot_entry_t        old_entry, new_entry;
  logic               mem_we;
  logic               tbl_hit;
  logic [ID_W-1:0]    tbl_hit_id;

  assign slot_ext      = {{SLOT_AW{1'b0}}, in_slot};
  assign slot_ok       = slot_ext < SLOT_EW'(MAX_BLOBS);
  assign s_axis_tready = (state_q == ST_IDLE) && !clr_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign finish        = (state_q == ST_CALC) && out_free;

  bcl_slot_mem #(
    .MAX_BLOBS (MAX_BLOBS),
    .SLOT_AW   (SLOT_AW)
  ) u_slot_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (slot_ext[SLOT_AW-1:0]),
    .rd_data_o  (old_entry),
    .wr_en_i    (mem_we),
    .wr_addr_i  (slot_q),
    .wr_data_i  (new_entry),
    .clr_busy_o (clr_busy)
  );

  // Update of the slot: shift in the new symbol and run the checks.
  logic [SCALE_W-1:0] area_lo, area_hi, last_lo, last_hi;
  logic               top_bit;
  logic [PAT_W-1:0]   new_pat;
  logic               ready_res, sync_found;

  assign area_lo = SCALE_W'(area_q) * SCALE_W'(RATIO_LO);
  assign area_hi = SCALE_W'(area_q) * SCALE_W'(RATIO_HI);
  assign last_lo = SCALE_W'(prev_area_q) * SCALE_W'(RATIO_LO);
  assign last_hi = SCALE_W'(prev_area_q) * SCALE_W'(RATIO_HI);

  always_comb begin
    top_bit = old_entry.pattern[PAT_W-1];
    if (src_q == SRC_BRIGHTNESS) begin
      if (area_lo > last_hi) begin
        top_bit = 1'b1;
      end else if (area_hi < last_lo) begin
        top_bit = 1'b0;
      end
    end else if (!colour_q[1]) begin
      // A non-negative colour is the symbol itself.
      top_bit = colour_q[0];
    end
  end

  assign new_pat    = {top_bit, old_entry.pattern[PAT_W-1:1]};
  assign ready_res  = age_q >= min_age_q;
  assign sync_found = ready_res && (bit_dist(new_pat, sync_word_q) <= sync_max_q);

  bcl_match #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_match (
    .clk_i         (clk_i),
    .wr_en_i       (accept && (s_axis_tuser == ACT_TABLE)),
    .wr_index_i    (in_eidx),
    .wr_pattern_i  (in_epat),
    .wr_id_i       (in_eid),
    .key_i         (new_pat),
    .leds_in_use_i (leds_q),
    .max_dist_i    (match_max_q),
    .hit_o         (tbl_hit),
    .hit_id_o      (tbl_hit_id)
  );

  // New slot entry, write-back and result word.
  always_comb begin
    new_entry = old_entry;
    mem_we    = 1'b0;
    m_data_d  = '0;
    if (finish && (act_q == ACT_FRAME) && in_range_q) begin
      mem_we = 1'b1;
      if (age_q == '0) begin
        new_entry = '0;
      end else begin
        new_entry.pattern = new_pat;
        if (ready_res && !old_entry.id_valid && tbl_hit) begin
          new_entry.id_valid = 1'b1;
          new_entry.id       = tbl_hit_id;
        end
        m_data_d[9:0]   = new_pat;
        m_data_d[10]    = ready_res;
        m_data_d[11]    = sync_found;
        m_data_d[12]    = new_entry.id_valid;
        m_data_d[20:13] = new_entry.id_valid ? new_entry.id : '0;
      end
    end
  end

  // Sequencer: read the slot, then update it once the output register is free.
  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (out_free) begin
          state_d   = ST_IDLE;
          m_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q       <= s_axis_tuser;
      in_range_q  <= slot_ok;
      slot_q      <= slot_ext[SLOT_AW-1:0];
      area_q      <= in_area;
      prev_area_q <= in_prev_area;
      age_q       <= in_age;
      colour_q    <= in_colour;
    end
    if (finish) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// ----- src/bcl_checker.sv -----
// Port-level checks for the blink code LED identifier, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module bcl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_tvalid_i,
  input wire logic        s_tready_i,
  input wire logic        m_tvalid_i,
  input wire logic        m_tready_i,
  input wire logic [23:0] m_tdata_i
);

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("stalled result changed");

  // Requests are taken one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("request taken while busy");

  // A new result only follows a cycle in which the block was busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_i) |-> $past(!s_tready_i))
    else $error("result without request");

  // Sync is only reported once the slot is old enough.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[11] |-> m_tdata_i[10])
    else $error("sync without ready");

  // An unknown LED carries a zero id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tdata_i[12] |-> m_tdata_i[20:13] == 8'd0)
    else $error("id without known LED");

endmodule

bind blink_code_led_identifier bcl_checker u_bcl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/blink_code_led_identifier_tb.sv -----
// Self-checking testbench for the blink code LED identifier: streams frame and table requests
// through the block, predicts every result and checks each one. Depends on bcl_pkg and the RTL.
`timescale 1ns / 100ps

module blink_code_led_identifier_tb;
  import bcl_pkg::*;

  localparam logic       SRC_COLOUR     = ~SRC_BRIGHTNESS;
  localparam logic [1:0] COLOUR_INVALID = 2'b11;
  localparam int unsigned N_SLOTS       = 64;
  localparam int unsigned N_ENTRIES     = 16;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // One request on the slave stream.
  typedef struct {
    logic              action;
    logic [SLOT_W-1:0] slot;
    logic [AREA_W-1:0] area;
    logic [AREA_W-1:0] prev_area;
    logic [AGE_W-1:0]  age;
    logic [1:0]        colour;
    logic [EIDX_W-1:0] entry_index;
    logic [PAT_W-1:0]  entry_pattern;
    logic [ID_W-1:0]   entry_led_id;
  } blink_req_t;

  // One result on the master stream, pattern in the lowest bits.
  typedef struct packed {
    logic [ID_W-1:0]  led_id;
    logic             led_known;
    logic             sync_found;
    logic             ready_res;
    logic [PAT_W-1:0] pattern;
  } blink_res_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // tdata: slot, area, prev_area, age, colour, entry_index, entry_pattern, entry_led_id, padding
  logic [71:0]          s_axis_tdata  = '0;
  // tuser: action
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // tdata: pattern, ready_res, sync_found, led_known, led_id, padding
  logic [23:0]          m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [PAT_W-1:0]     cfg_wdata_i   = '0;

  // Mirror of the block's configuration.
  logic              cur_source    = SRC_BRIGHTNESS;
  logic [AGE_W-1:0]  cur_min_age   = 8'd9;
  logic [PAT_W-1:0]  cur_sync_word = 10'h3FF;
  logic [DIST_W-1:0] cur_sync_max  = 4'd1;
  logic [DIST_W-1:0] cur_match_max = 4'd0;
  logic [LEDS_W-1:0] cur_leds      = 5'd16;

  // Mirror of the slot memory and of the LED pattern table.
  logic [PAT_W-1:0] slot_blink_pat [N_SLOTS];
  logic             slot_led_known [N_SLOTS];
  logic [ID_W-1:0]  slot_led_num   [N_SLOTS];
  logic [PAT_W-1:0] table_blink_pat [N_ENTRIES];
  logic [ID_W-1:0]  table_led_num   [N_ENTRIES];

  // Per-slot blob tracks that the random stimulus follows.
  int unsigned      trk_age [N_SLOTS];
  logic [PAT_W-1:0] trk_pat [N_SLOTS];

  blink_req_t  requests_pending [$];
  blink_res_t  blink_results_due [$];
  blink_req_t  req_now;
  blink_req_t  req_next;
  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  blink_code_led_identifier DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < N_SLOTS; i++) begin
      slot_blink_pat[i] = '0;
      slot_led_known[i] = 1'b0;
      slot_led_num[i]   = '0;
      trk_age[i]        = 0;
      trk_pat[i]        = '0;
    end
    for (int j = 0; j < N_ENTRIES; j++) begin
      table_blink_pat[j] = '0;
      table_led_num[j]   = '0;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Works out the result of one request and updates the mirrored state.
  function automatic blink_res_t compute_blink_result(input blink_req_t r);
    blink_res_t       res;
    logic [PAT_W-1:0] prev;
    logic [PAT_W-1:0] nxt;
    int unsigned      ar;
    int unsigned      la;
    int unsigned      lim;
    res = '0;
    if (r.action == ACT_TABLE) begin
      table_blink_pat[r.entry_index] = r.entry_pattern;
      table_led_num[r.entry_index]   = r.entry_led_id;
      return res;
    end
    // A blob of age zero starts its slot afresh.
    if (r.age == '0) begin
      slot_blink_pat[r.slot] = '0;
      slot_led_known[r.slot] = 1'b0;
      slot_led_num[r.slot]   = '0;
      return res;
    end
    prev = slot_blink_pat[r.slot];
    nxt  = prev >> 1;
    if (cur_source == SRC_COLOUR) begin
      // A negative colour leaves the previous top bit in place.
      nxt[PAT_W-1] = r.colour[1] ? prev[PAT_W-1] : r.colour[0];
    end else begin
      // Brightness with a hysteresis of eleven to ten either way.
      ar = r.area;
      la = r.prev_area;
      if (ar * 10 > la * 11) begin
        nxt[PAT_W-1] = 1'b1;
      end else if (ar * 11 < la * 10) begin
        nxt[PAT_W-1] = 1'b0;
      end else begin
        nxt[PAT_W-1] = prev[PAT_W-1];
      end
    end
    slot_blink_pat[r.slot] = nxt;
    res.pattern   = nxt;
    res.ready_res = (r.age >= cur_min_age);
    if (res.ready_res) begin
      res.sync_found = ($countones(nxt ^ cur_sync_word) <= cur_sync_max);
      // The first close enough table entry binds its id to the slot.
      if (!slot_led_known[r.slot]) begin
        lim = (cur_leds > N_ENTRIES) ? N_ENTRIES : cur_leds;
        for (int j = 0; j < lim && !slot_led_known[r.slot]; j++) begin
          if ($countones(nxt ^ table_blink_pat[j]) <= cur_match_max) begin
            slot_led_known[r.slot] = 1'b1;
            slot_led_num[r.slot]   = table_led_num[j];
          end
        end
      end
    end
    res.led_known = slot_led_known[r.slot];
    res.led_id    = slot_led_known[r.slot] ? slot_led_num[r.slot] : '0;
    return res;
  endfunction

  // A request with every field random; colour is drawn from zero, one and the invalid code only.
  function automatic blink_req_t random_request();
    blink_req_t r;
    r.action        = 1'($urandom_range(1));
    r.slot          = SLOT_W'($urandom_range(N_SLOTS - 1));
    r.area          = AREA_W'($urandom);
    r.prev_area     = AREA_W'($urandom);
    r.age           = ($urandom_range(9) == 0) ? 8'hFF : AGE_W'($urandom);
    case ($urandom_range(2))
      0:       r.colour = 2'b00;
      1:       r.colour = 2'b01;
      default: r.colour = COLOUR_INVALID;
    endcase
    r.entry_index   = EIDX_W'($urandom);
    r.entry_pattern = PAT_W'($urandom);
    r.entry_led_id  = ID_W'($urandom);
    return r;
  endfunction

  function automatic blink_req_t table_request(input int unsigned idx, input logic [PAT_W-1:0] pat,
                                               input logic [ID_W-1:0] id);
    blink_req_t r;
    r = random_request();
    r.action        = ACT_TABLE;
    r.entry_index   = EIDX_W'(idx);
    r.entry_pattern = pat;
    r.entry_led_id  = id;
    return r;
  endfunction

  // A frame request whose new top bit is b under the current symbol source, or one that keeps
  // the previous bit when hold is set; in brightness mode one in twenty keeps its random areas.
  function automatic blink_req_t frame_request(input int unsigned slot, input int unsigned age,
                                               input logic b, input logic hold);
    blink_req_t  r;
    int unsigned la;
    r = random_request();
    r.action = ACT_FRAME;
    r.slot   = SLOT_W'(slot);
    r.age    = AGE_W'(age);
    if (cur_source == SRC_COLOUR) begin
      r.colour = hold ? COLOUR_INVALID : {1'b0, b};
    end else if ($urandom_range(19) != 0) begin
      la          = $urandom_range(6000, 1);
      r.prev_area = AREA_W'(la);
      r.area      = hold ? AREA_W'(la) : (b ? AREA_W'(la * 2) : AREA_W'(la / 2));
    end
    return r;
  endfunction

  function automatic blink_req_t area_request(input int unsigned slot, input int unsigned age,
                                              input int unsigned area, input int unsigned last);
    blink_req_t r;
    r = frame_request(slot, age, 1'b0, 1'b0);
    r.area      = AREA_W'(area);
    r.prev_area = AREA_W'(last);
    return r;
  endfunction

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= PAT_W'(val);
    case (idx)
      CFG_SYMBOL_SOURCE: cur_source    = 1'(val);
      CFG_MIN_AGE:       cur_min_age   = AGE_W'(val);
      CFG_SYNC_WORD:     cur_sync_word = PAT_W'(val);
      CFG_SYNC_MAX:      cur_sync_max  = DIST_W'(val);
      CFG_MATCH_MAX:     cur_match_max = DIST_W'(val);
      CFG_LEDS_IN_USE:   cur_leds      = LEDS_W'(val);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(input logic src, input int unsigned min_age,
                                input int unsigned sync_word, input int unsigned sync_max,
                                input int unsigned match_max, input int unsigned leds);
    set_register(CFG_SYMBOL_SOURCE, src);
    set_register(CFG_MIN_AGE, min_age);
    set_register(CFG_SYNC_WORD, sync_word);
    set_register(CFG_SYNC_MAX, sync_max);
    set_register(CFG_MATCH_MAX, match_max);
    set_register(CFG_LEDS_IN_USE, leds);
  endtask

  // Waits until every request has been taken and every result has come back. The queues and
  // the valid flag are looked at once the edge has settled, so that they agree with each other.
  task automatic wait_drained();
    while (requests_pending.size() != 0 || s_axis_tvalid || blink_results_due.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 78; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 78; end
      default: begin send_idle_pct = 26; stall_pct = 26; end
    endcase
  endtask

  // Stimulus: directed requests first, then random phases over several settings.
  initial begin
    int unsigned pool_base;
    int unsigned s;
    int unsigned roll;
    blink_req_t  r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Brightness edges, clearing, extreme areas and a full run to the sync word.
    apply_settings(SRC_BRIGHTNESS, 2, 10'h3FF, 1, 0, 2);
    set_idling(0);
    requests_pending.push_back(table_request(0, 10'h3FF, 8'hFF));
    requests_pending.push_back(table_request(1, 10'h000, 8'h00));
    requests_pending.push_back(area_request(0, 1, 12, 10));
    requests_pending.push_back(area_request(0, 2, 11, 10));
    requests_pending.push_back(area_request(0, 3, 10, 11));
    requests_pending.push_back(area_request(0, 4, 9, 11));
    requests_pending.push_back(area_request(0, 5, 16'hFFFF, 0));
    requests_pending.push_back(area_request(0, 6, 0, 16'hFFFF));
    requests_pending.push_back(area_request(0, 0, 50, 10));
    for (int a = 1; a <= 10; a++) begin
      requests_pending.push_back(frame_request(63, (a == 10) ? 255 : a, 1'b1, 1'b0));
    end
    wait_drained();

    // Colour bits: one, zero and invalid.
    apply_settings(SRC_COLOUR, 2, 10'h3FF, 1, 0, 2);
    requests_pending.push_back(frame_request(5, 1, 1'b1, 1'b0));
    requests_pending.push_back(frame_request(5, 2, 1'b0, 1'b0));
    requests_pending.push_back(frame_request(5, 3, 1'b0, 1'b1));

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: apply_settings(SRC_BRIGHTNESS, 9, 10'h3FF, 1, 0, 16);
        1: apply_settings(SRC_COLOUR, 10, 10'h2AA, 2, 1, 16);
        2: apply_settings(SRC_BRIGHTNESS, 0, 10'h000, 0, 0, 31);
        3: apply_settings(SRC_COLOUR, 255, 10'h3FF, 10, 10, 0);
        4: apply_settings(SRC_BRIGHTNESS, 5, $urandom_range(1023), 3, 2, 8);
        5: apply_settings(SRC_COLOUR, 12, $urandom_range(1023), 10, 3, 1);
        6: apply_settings(SRC_BRIGHTNESS, 10, 10'h155, 4, 0, 16);
        default: apply_settings(SRC_COLOUR, 1, $urandom_range(1023), 0, 10, 17);
      endcase
      set_idling(ph % 4);
      // The rest of the table is loaded before the search may reach it.
      if (ph == 0) begin
        for (int j = 2; j < N_ENTRIES; j++) begin
          requests_pending.push_back(table_request(j, PAT_W'($urandom), ID_W'($urandom)));
        end
      end
      pool_base = $urandom_range(N_SLOTS - 8);
      for (int k = 0; k < 190; k++) begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          requests_pending.push_back(table_request($urandom_range(N_ENTRIES - 1),
                                                   PAT_W'($urandom), ID_W'($urandom)));
        end else if (roll < 15) begin
          requests_pending.push_back(random_request());
        end else begin
          // A tracked blob blinks its target pattern, with some noise and the odd restart.
          s = pool_base + $urandom_range(7);
          if (trk_age[s] != 0 && $urandom_range(99) < 3) begin
            requests_pending.push_back(frame_request(s, 0, 1'b0, 1'b0));
            trk_age[s] = 0;
            trk_pat[s] = ($urandom_range(9) < 7) ? table_blink_pat[$urandom_range(N_ENTRIES - 1)]
                                                : PAT_W'($urandom);
          end else begin
            if (trk_age[s] < 255) begin
              trk_age[s]++;
            end
            r = frame_request(s, trk_age[s], trk_pat[s][(trk_age[s] - 1) % PAT_W],
                              ($urandom_range(99) < 8));
            requests_pending.push_back(r);
          end
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("blink_code_led_identifier_tb OK");
    end else begin
      $display("blink_code_led_identifier_tb NOT OK");
    end
    $finish;
  end

  // Request driver: predicts on every accepted request and presents the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        blink_results_due.push_back(compute_blink_result(req_now));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (requests_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_next = requests_pending.pop_front();
          req_now       <= req_next;
          s_axis_tdata  <= {2'b00, req_next.entry_led_id, req_next.entry_pattern,
                            req_next.entry_index, req_next.colour, req_next.age,
                            req_next.prev_area, req_next.area, req_next.slot};
          s_axis_tuser  <= req_next.action;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted result against the oldest one due.
  always @(posedge clk_i) begin
    blink_res_t got;
    blink_res_t due;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[20:0];
        if (blink_results_due.size() == 0) begin
          report_mismatch($sformatf("result %h with none due", got));
        end else begin
          due = blink_results_due.pop_front();
          if (got.pattern !== due.pattern)
            report_mismatch($sformatf("pattern %h, expected %h", got.pattern, due.pattern));
          if (got.ready_res !== due.ready_res)
            report_mismatch($sformatf("ready_res %b, expected %b", got.ready_res, due.ready_res));
          if (got.sync_found !== due.sync_found)
            report_mismatch($sformatf("sync_found %b, expected %b", got.sync_found,
                                      due.sync_found));
          if (got.led_known !== due.led_known)
            report_mismatch($sformatf("led_known %b, expected %b", got.led_known, due.led_known));
          if (got.led_id !== due.led_id)
            report_mismatch($sformatf("led_id %h, expected %h", got.led_id, due.led_id));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("blink_code_led_identifier_tb NOT OK");
      $finish;
    end
  end

endmodule

// ----- blink_code_led_identifier.f -----
src/bcl_pkg.sv
src/bcl_slot_mem.sv
src/bcl_match.sv
src/blink_code_led_identifier.sv
src/bcl_checker.sv
tb/blink_code_led_identifier_tb.sv
